/* design/dade_pkg.sv */
package dade_pkg;

   localparam int LEVEL_W = 32;
   localparam int ENV_W   = 16;
   localparam int CSR_IDX_W = 8;
   localparam int REQ_W   = 8;
   localparam int RSP_W   = 40;

   localparam logic [LEVEL_W-1:0] ENV_TOP = 32'hFFFF_0000;

   typedef enum logic [1:0] {
      STAGE_IDLE   = 2'd0,
      STAGE_ATTACK = 2'd1,
      STAGE_DECAY  = 2'd2
   } stage_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ATTACK_STEP_A = 8'd0,
      CSR_DECAY_STEP_A  = 8'd1,
      CSR_ATTACK_STEP_B = 8'd2,
      CSR_DECAY_STEP_B  = 8'd3
   } csr_index_type;

   typedef struct packed {
      logic [ENV_W-1:0] env;
      logic             busy;
   } chan_out_type;

endpackage

/* design/dual_attack_decay_envelope.sv */
// Two-channel attack-decay envelope generator.
// req_ carries one tick item per handshake; bit 0 triggers channel A, bit 1
// channel B. A trigger restarts that channel from zero in attack, and the
// same tick then advances it.
// rsp_ returns one item per tick: both 16-bit levels and the busy flags,
// taken after that tick's update.
// csr_ writes the four 32-bit step registers (index 0..3, others ignored);
// always ready, write only while no tick is in flight.
// The result item is registered in the output register, or in the skid entry while that is full.
// Throughput: one tick per cycle while req_tready is high; each channel update
// is a single add or subtract plus compare, from channel state to output register.
// A two-entry output buffer (register plus skid) keeps req_tready free of
// any combinational path from rsp_tready. While the receiver stalls, up to
// two results are held and req_tready then drops until one is taken.
// Reset clears both levels to zero, both channels to idle, the step
// registers to zero and the output buffer to empty.
module dual_attack_decay_envelope (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [dade_pkg::REQ_W-1:0]      req_tdata,  // trig_a, trig_b, zero pad
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [dade_pkg::RSP_W-1:0]      rsp_tdata,  // env_out_a, env_out_b, busy_a,
                                                       // busy_b, any_busy, zero pad
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [dade_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [dade_pkg::LEVEL_W-1:0]    csr_data
);

   logic [dade_pkg::LEVEL_W-1:0] rise_step_a_ff;
   logic [dade_pkg::LEVEL_W-1:0] fall_step_a_ff;
   logic [dade_pkg::LEVEL_W-1:0] rise_step_b_ff;
   logic [dade_pkg::LEVEL_W-1:0] fall_step_b_ff;

   logic                       tick;
   dade_pkg::chan_out_type     res_a;
   dade_pkg::chan_out_type     res_b;
   logic [dade_pkg::RSP_W-1:0] rsp_word;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rise_step_a_ff <= '0;
         fall_step_a_ff <= '0;
         rise_step_b_ff <= '0;
         fall_step_b_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            dade_pkg::CSR_ATTACK_STEP_A: rise_step_a_ff <= csr_data;
            dade_pkg::CSR_DECAY_STEP_A:  fall_step_a_ff <= csr_data;
            dade_pkg::CSR_ATTACK_STEP_B: rise_step_b_ff <= csr_data;
            dade_pkg::CSR_DECAY_STEP_B:  fall_step_b_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign tick = req_tvalid && req_tready;

   dade_channel u_chan_a (
      .clock     (clock),
      .reset     (reset),
      .tick      (tick),
      .trig      (req_tdata[0]),
      .rise_step (rise_step_a_ff),
      .fall_step (fall_step_a_ff),
      .result    (res_a)
   );

   dade_channel u_chan_b (
      .clock     (clock),
      .reset     (reset),
      .tick      (tick),
      .trig      (req_tdata[1]),
      .rise_step (rise_step_b_ff),
      .fall_step (fall_step_b_ff),
      .result    (res_b)
   );

   assign rsp_word = {5'b0, res_a.busy | res_b.busy, res_b.busy, res_a.busy,
                      res_b.env, res_a.env};

   dade_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (rsp_word),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_tdata)
   );

endmodule

/* design/dade_channel.sv */
module dade_channel (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            tick,
   input  logic                            trig,
   input  logic [dade_pkg::LEVEL_W-1:0]    rise_step,
   input  logic [dade_pkg::LEVEL_W-1:0]    fall_step,
   output dade_pkg::chan_out_type          result
);

   logic [dade_pkg::LEVEL_W-1:0] acc_ff;
   logic [dade_pkg::LEVEL_W-1:0] acc_in;
   dade_pkg::stage_type          stage_ff;
   dade_pkg::stage_type          stage_in;

   logic [dade_pkg::LEVEL_W-1:0] acc_start;
   dade_pkg::stage_type          stage_start;
   logic [dade_pkg::LEVEL_W:0]   sum;

   always_comb begin
      acc_start   = trig ? '0 : acc_ff;
      stage_start = trig ? dade_pkg::STAGE_ATTACK : stage_ff;
      sum         = {1'b0, acc_start} + {1'b0, rise_step};
      acc_in      = acc_start;
      stage_in    = stage_start;
      case (stage_start)
         dade_pkg::STAGE_ATTACK: begin
            if (sum[dade_pkg::LEVEL_W] || sum[dade_pkg::LEVEL_W-1:0] >= dade_pkg::ENV_TOP) begin
               acc_in   = dade_pkg::ENV_TOP;
               stage_in = dade_pkg::STAGE_DECAY;
            end else begin
               acc_in = sum[dade_pkg::LEVEL_W-1:0];
            end
         end
         dade_pkg::STAGE_DECAY: begin
            if (acc_start <= fall_step) begin
               acc_in   = '0;
               stage_in = dade_pkg::STAGE_IDLE;
            end else begin
               acc_in = acc_start - fall_step;
            end
         end
         default: begin
            acc_in   = acc_start;
            stage_in = stage_start;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff   <= '0;
         stage_ff <= dade_pkg::STAGE_IDLE;
      end else if (tick) begin
         acc_ff   <= acc_in;
         stage_ff <= stage_in;
      end
   end

   assign result.env  = acc_in[dade_pkg::LEVEL_W-1 -: dade_pkg::ENV_W];
   assign result.busy = (stage_in == dade_pkg::STAGE_ATTACK) ||
                        (stage_in == dade_pkg::STAGE_DECAY);

endmodule

/* design/dade_out_buf.sv */
module dade_out_buf (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  logic [dade_pkg::RSP_W-1:0]  in_data,
   output logic                        out_valid,
   input  logic                        out_ready,
   output logic [dade_pkg::RSP_W-1:0]  out_data
);

   logic                       out_valid_ff;
   logic                       out_valid_in;
   logic [dade_pkg::RSP_W-1:0] out_data_ff;
   logic [dade_pkg::RSP_W-1:0] out_data_in;
   logic                       skid_valid_ff;
   logic                       skid_valid_in;
   logic [dade_pkg::RSP_W-1:0] skid_data_ff;
   logic [dade_pkg::RSP_W-1:0] skid_data_in;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (out_valid_ff && out_ready) begin
         if (skid_valid_ff) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = 1'b0;
         end
      end
      if (in_valid && in_ready) begin
         if (out_valid_in) begin
            skid_data_in  = in_data;
            skid_valid_in = 1'b1;
         end else begin
            out_data_in  = in_data;
            out_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign in_ready  = !skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

endmodule

/* dv/envelope_checker.sv */
`timescale 1ns / 1ps

module envelope_checker
   import dade_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_W-1:0]      req_tdata,  // trig_a, trig_b, zero pad
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_W-1:0]      rsp_tdata,  // env_out_a, env_out_b, busy_a, busy_b,
                                             // any_busy, zero pad
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [LEVEL_W-1:0]    csr_data,
   output int                    failures,
   output int                    outstanding
);

   typedef struct {
      chan_out_type chan_a;
      chan_out_type chan_b;
      logic         any_busy;
   } tick_result_type;

   logic [LEVEL_W-1:0] rise_step [2];
   logic [LEVEL_W-1:0] fall_step [2];
   logic [LEVEL_W-1:0] level [2];
   stage_type          phase [2];
   tick_result_type    expected_levels [$];
   int                 fail_total = 0;
   int                 queued = 0;

   assign failures    = fail_total;
   assign outstanding = queued;

   function automatic void advance_channel(input int ch);
      logic [LEVEL_W:0] sum;
      case (phase[ch])
         STAGE_ATTACK: begin
            sum = {1'b0, level[ch]} + {1'b0, rise_step[ch]};
            if (sum[LEVEL_W] || sum[LEVEL_W-1:0] >= ENV_TOP) begin
               level[ch] = ENV_TOP;
               phase[ch] = STAGE_DECAY;
            end else begin
               level[ch] = sum[LEVEL_W-1:0];
            end
         end
         STAGE_DECAY: begin
            if (level[ch] <= fall_step[ch]) begin
               level[ch] = '0;
               phase[ch] = STAGE_IDLE;
            end else begin
               level[ch] = level[ch] - fall_step[ch];
            end
         end
         default: ;
      endcase
   endfunction

   function automatic tick_result_type envelope_tick(input logic trig_a, input logic trig_b);
      tick_result_type r;
      if (trig_a) begin
         level[0] = '0;
         phase[0] = STAGE_ATTACK;
      end
      if (trig_b) begin
         level[1] = '0;
         phase[1] = STAGE_ATTACK;
      end
      advance_channel(0);
      advance_channel(1);
      r.chan_a.env  = level[0][LEVEL_W-1 -: ENV_W];
      r.chan_b.env  = level[1][LEVEL_W-1 -: ENV_W];
      r.chan_a.busy = (phase[0] == STAGE_ATTACK) || (phase[0] == STAGE_DECAY);
      r.chan_b.busy = (phase[1] == STAGE_ATTACK) || (phase[1] == STAGE_DECAY);
      r.any_busy    = r.chan_a.busy | r.chan_b.busy;
      return r;
   endfunction

   task automatic check_field(input string name, input logic [ENV_W-1:0] exp_val,
                              input logic [ENV_W-1:0] got_val);
      if (got_val !== exp_val) begin
         $error("%s expected %0h got %0h", name, exp_val, got_val);
         fail_total++;
      end
   endtask

   always @(posedge clock) begin
      tick_result_type exp_r;
      if (reset) begin
         rise_step = '{default: '0};
         fall_step = '{default: '0};
         level     = '{default: '0};
         phase     = '{default: STAGE_IDLE};
         expected_levels.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ATTACK_STEP_A: rise_step[0] = csr_data;
               CSR_DECAY_STEP_A:  fall_step[0] = csr_data;
               CSR_ATTACK_STEP_B: rise_step[1] = csr_data;
               CSR_DECAY_STEP_B:  fall_step[1] = csr_data;
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_levels.size() == 0) begin
               $error("result item with no tick outstanding: %0h", rsp_tdata);
               fail_total++;
            end else begin
               exp_r = expected_levels.pop_front();
               check_field("env_out_a", exp_r.chan_a.env, rsp_tdata[ENV_W-1:0]);
               check_field("env_out_b", exp_r.chan_b.env, rsp_tdata[2*ENV_W-1:ENV_W]);
               check_field("busy_a", ENV_W'(exp_r.chan_a.busy), ENV_W'(rsp_tdata[2*ENV_W]));
               check_field("busy_b", ENV_W'(exp_r.chan_b.busy), ENV_W'(rsp_tdata[2*ENV_W+1]));
               check_field("any_busy", ENV_W'(exp_r.any_busy), ENV_W'(rsp_tdata[2*ENV_W+2]));
            end
         end
         if (req_tvalid && req_tready)
            expected_levels.push_back(envelope_tick(req_tdata[0], req_tdata[1]));
      end
      queued = expected_levels.size();
   end

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps

module testbench;
   import dade_pkg::*;

   localparam int ITEM_TARGET = 1550;
   localparam int CYCLE_LIMIT = 400000;
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 8'd9;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [REQ_W-1:0]     req_tdata = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [RSP_W-1:0]     rsp_tdata;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [LEVEL_W-1:0]   csr_data = '0;

   int failures;
   int outstanding;
   int ticks_sent = 0;
   int tx_idle_pct = 0;
   int rx_idle_pct = 0;
   int cycle_count = 0;

   always #5 clock = ~clock;

   dual_attack_decay_envelope i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   envelope_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .failures    (failures),
      .outstanding (outstanding)
   );

   always @(negedge clock) rsp_tready <= ($urandom_range(0, 99) >= rx_idle_pct);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL dual_attack_decay_envelope");
         $finish;
      end
   end

   task automatic send_tick(input logic trig_a, input logic trig_b);
      @(negedge clock);
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_W'({trig_b, trig_a});
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      ticks_sent++;
   endtask

   // hold off until every result item is back
   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [LEVEL_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [LEVEL_W-1:0] pick_step();
      case ($urandom_range(0, 11))
         0:       return '0;
         1:       return '1;
         2:       return ENV_TOP;
         3:       return $urandom();
         4:       return $urandom_range(1, 16'hFFFF);
         default: return $urandom_range(32'h0200_0000, 32'h3000_0000);
      endcase
   endfunction

   initial begin
      int trig_pct;
      int burst;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      tx_idle_pct = 36;
      rx_idle_pct = 45;

      // zero steps: attack holds at zero
      send_tick(1'b0, 1'b0);
      send_tick(1'b1, 1'b1);
      send_tick(1'b0, 1'b0);
      send_tick(1'b0, 1'b0);
      drain();

      // immediate clamp past the top and at exact top, full and exact decay
      write_reg(CSR_ATTACK_STEP_A, '1);
      write_reg(CSR_DECAY_STEP_A, '1);
      write_reg(CSR_ATTACK_STEP_B, ENV_TOP);
      write_reg(CSR_DECAY_STEP_B, 32'h7FFF_8000);
      write_reg(CSR_UNMAPPED, 32'h1234_5678);
      send_tick(1'b1, 1'b1);
      send_tick(1'b0, 1'b0);
      send_tick(1'b0, 1'b0);
      send_tick(1'b1, 1'b0);
      send_tick(1'b0, 1'b1);
      send_tick(1'b1, 1'b1);
      drain();

      // carry out of 32 bits, zero decay holds at top, retrigger while busy
      write_reg(CSR_ATTACK_STEP_A, 32'h8000_0000);
      write_reg(CSR_DECAY_STEP_A, '0);
      write_reg(CSR_ATTACK_STEP_B, 32'h0000_0001);
      write_reg(CSR_DECAY_STEP_B, '1);
      send_tick(1'b1, 1'b1);
      send_tick(1'b0, 1'b0);
      send_tick(1'b0, 1'b0);
      send_tick(1'b0, 1'b0);
      send_tick(1'b1, 1'b0);
      send_tick(1'b0, 1'b1);
      drain();

      while (ticks_sent < ITEM_TARGET) begin
         if (ticks_sent > 2 * ITEM_TARGET / 3) begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
         end else if (ticks_sent > ITEM_TARGET / 3) begin
            tx_idle_pct = 45;
            rx_idle_pct = 36;
         end
         write_reg(CSR_ATTACK_STEP_A, pick_step());
         write_reg(CSR_DECAY_STEP_A, pick_step());
         write_reg(CSR_ATTACK_STEP_B, pick_step());
         write_reg(CSR_DECAY_STEP_B, pick_step());
         case ($urandom_range(0, 5))
            0, 1:    trig_pct = 2;
            2:       trig_pct = 5;
            3:       trig_pct = 1;
            4:       trig_pct = 20;
            default: trig_pct = 60;
         endcase
         burst = $urandom_range(40, 160);
         repeat (burst) begin
            send_tick($urandom_range(0, 99) < trig_pct, $urandom_range(0, 99) < trig_pct);
            if ($urandom_range(0, 49) == 0) drain();
         end
         drain();
      end

      repeat (4) @(posedge clock);
      if (failures == 0) begin
         $display("PASS dual_attack_decay_envelope");
      end else begin
         $display("FAIL dual_attack_decay_envelope");
      end
      $finish;
   end

endmodule
